### sv/ccs_pkg.sv
// Shared types, character codes and helper functions for the chat control code stripper.
package ccs_pkg;

	localparam int unsigned QDEPTH = 4;

	localparam logic [7:0] CH_SOH    = 8'h01;
	localparam logic [7:0] CH_BOLD   = 8'h02;
	localparam logic [7:0] CH_BELL   = 8'h07;
	localparam logic [7:0] CH_REV    = 8'h16;
	localparam logic [7:0] CH_ULINE  = 8'h1f;
	localparam logic [7:0] CH_COLOR  = 8'h03;
	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_out;
	} out_req_t;

	// Up to two results per input byte.
	typedef struct packed {
		logic [1:0] cnt;
		out_req_t   r0;
		out_req_t   r1;
	} scan_res_t;

	typedef enum logic [2:0] {
		ST_NORMAL     = 3'd0,
		ST_HELD_C3    = 3'd1,
		ST_FG1        = 3'd2,
		ST_FG2        = 3'd3,
		ST_HELD_COMMA = 3'd4,
		ST_BG1        = 3'd5,
		ST_ESC        = 3'd6,
		ST_CSI        = 3'd7
	} scan_state_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// State after a byte seen as plain text.
	function automatic scan_state_t normal_next(input logic [7:0] b);
		scan_state_t s;
		if (b == CH_COLOR) begin
			s = ST_HELD_C3;
		end else if (b == CH_ESC) begin
			s = ST_ESC;
		end else begin
			s = ST_NORMAL;
		end
		return s;
	endfunction

	// Plain text byte that survives.
	function automatic logic normal_keep(input logic [7:0] b);
		return !(b == CH_SOH || b == CH_BOLD || b == CH_BELL || b == CH_REV ||
			b == CH_ULINE || b == CH_COLOR || b == CH_ESC);
	endfunction

endpackage

### sv/ccs_scan.sv
// Byte scanner: code state register and the per-byte result logic.
module ccs_scan import ccs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_req_t   item,
	input  logic      adv,
	output scan_res_t res
);

	scan_state_t state_q;
	scan_state_t scan_nxt;
	scan_state_t state_d;
	logic [7:0]  b;
	logic        dig;

	assign b   = item.in_byte;
	assign dig = is_digit(item.in_byte);

	function automatic scan_res_t push(input scan_res_t r, input logic [7:0] c);
		scan_res_t o;
		o = r;
		if (r.cnt == 2'd0) begin
			o.r0 = '{out_byte: c, has_byte: 1'b1, last_out: 1'b0};
			o.cnt = 2'd1;
		end else begin
			o.r1 = '{out_byte: c, has_byte: 1'b1, last_out: 1'b0};
			o.cnt = 2'd2;
		end
		return o;
	endfunction

	// next state
	always_comb begin
		unique case (state_q)
			ST_HELD_C3:    scan_nxt = dig ? ST_FG1 : normal_next(b);
			ST_FG1: begin
				if (dig) begin
					scan_nxt = ST_FG2;
				end else if (b == CH_COMMA) begin
					scan_nxt = ST_HELD_COMMA;
				end else begin
					scan_nxt = normal_next(b);
				end
			end
			ST_FG2:        scan_nxt = (b == CH_COMMA) ? ST_HELD_COMMA : normal_next(b);
			ST_HELD_COMMA: scan_nxt = dig ? ST_BG1 : normal_next(b);
			ST_BG1:        scan_nxt = dig ? ST_NORMAL : normal_next(b);
			ST_ESC:        scan_nxt = (b == CH_LBRACK) ? ST_CSI : normal_next(b);
			ST_CSI:        scan_nxt = (dig || b == CH_SEMI) ? ST_CSI : ST_NORMAL;
			ST_NORMAL:     scan_nxt = normal_next(b);
			default:       scan_nxt = ST_NORMAL;
		endcase
		state_d = item.end_of_text ? ST_NORMAL : scan_nxt;
	end

	// results
	always_comb begin
		scan_res_t r;
		r = '0;
		unique case (state_q)
			ST_HELD_C3: begin
				if (!dig) begin
					r = push(r, CH_COLOR);
					if (normal_keep(b)) r = push(r, b);
				end
			end
			ST_FG1: begin
				if (!dig && b != CH_COMMA && normal_keep(b)) r = push(r, b);
			end
			ST_FG2: begin
				if (b != CH_COMMA && normal_keep(b)) r = push(r, b);
			end
			ST_HELD_COMMA: begin
				if (!dig) begin
					r = push(r, CH_COMMA);
					if (normal_keep(b)) r = push(r, b);
				end
			end
			ST_BG1: begin
				if (!dig && normal_keep(b)) r = push(r, b);
			end
			ST_ESC: begin
				if (b != CH_LBRACK && normal_keep(b)) r = push(r, b);
			end
			ST_CSI: begin
				r = '0;
			end
			ST_NORMAL: begin
				if (normal_keep(b)) r = push(r, b);
			end
			default: begin
				r = '0;
			end
		endcase
		if (item.end_of_text) begin
			// flush a held 0x03 or comma, then mark the final result
			if (scan_nxt == ST_HELD_C3) begin
				r = push(r, CH_COLOR);
			end else if (scan_nxt == ST_HELD_COMMA) begin
				r = push(r, CH_COMMA);
			end
			if (r.cnt == 2'd0) begin
				r.r0 = '{out_byte: 8'h00, has_byte: 1'b0, last_out: 1'b1};
				r.cnt = 2'd1;
			end else if (r.cnt == 2'd1) begin
				r.r0.last_out = 1'b1;
			end else begin
				r.r1.last_out = 1'b1;
			end
		end
		res = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORMAL;
		end else if (adv) begin
			state_q <= state_d;
		end
	end

	a_eot_back_to_normal: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.end_of_text |=> state_q == ST_NORMAL)
		else $error("scan state not normal after end of text");

	a_eot_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.end_of_text |-> res.cnt != 2'd0)
		else $error("end of text produced no result");

	a_last_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		res.cnt == 2'd2 |-> !res.r0.last_out)
		else $error("last flag on a non-final result");

endmodule

### sv/ccs_queue.sv
// Result queue: takes up to two results per cycle, hands out one per request.
module ccs_queue import ccs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_res_t push,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output out_req_t  data
);

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	out_req_t           mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];
	assign pop   = valid && !stall;
	// two free slots regardless of what leaves this cycle
	assign room  = (count_q <= CNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> (count_q + CNT_W'(push.cnt)) <= CNT_W'(QDEPTH))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("result queue count out of range");

endmodule

### sv/chat_control_code_stripper.sv
// A result passes through the input register and then the result queue before it is
// offered at the result port; the input register holds while the queue lacks room.
// Throughput: one byte per cycle while the result queue has room; a byte that yields
// two results (a released 0x03 or comma plus the byte itself, or a held byte flushed
// at end of text) leaves the result port as two separate results.
// The input register advances when the four-entry result queue has two free slots.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and puts the
// scanner in normal text state.
module chat_control_code_stripper import ccs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     text_valid,
	output logic     text_stall,
	input  in_req_t  text,
	output logic     kept_valid,
	input  logic     kept_stall,
	output out_req_t kept
);

	logic      valid_s1;
	in_req_t   item_s1;
	logic      room;
	logic      advance;
	logic      accept;
	scan_res_t res;
	scan_res_t push_res;

	assign advance    = valid_s1 && room;
	assign text_stall = valid_s1 && !room;
	assign accept     = text_valid && !text_stall;

	always_comb begin
		push_res = res;
		push_res.cnt = advance ? res.cnt : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= text;
		end
	end

	ccs_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.adv    (advance),
		.res    (res)
	);

	ccs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_res),
		.room   (room),
		.valid  (kept_valid),
		.stall  (kept_stall),
		.data   (kept)
	);

endmodule
